### rtl/core/idf_pkg.sv
package idf_pkg;

    localparam int FRAME_BYTES = 19;
    localparam int CRC_CELLS   = 16;

    localparam logic [7:0]  HDR_BYTE0 = 8'h55;
    localparam logic [7:0]  HDR_BYTE1 = 8'hAA;
    localparam logic [7:0]  TAIL_BYTE = 8'h0A;
    localparam logic [7:0]  ID_MIN    = 8'h01;
    localparam logic [7:0]  ID_MAX    = 8'h03;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    typedef logic [15:0] crc_table_t [256];

    function automatic crc_table_t build_crc_table();
        crc_table_t tbl;
        logic [16:0] v;
        for (int idx = 0; idx < 256; idx++) begin
            v = {1'b0, idx[7:0], 8'h00};
            for (int k = 0; k < 8; k++) begin
                v = {v[15:0], 1'b0};
                if (v[16]) begin
                    v = v ^ {1'b0, CRC_POLY};
                end
                v[16] = 1'b0;
            end
            tbl[idx] = v[15:0];
        end
        return tbl;
    endfunction

    localparam crc_table_t CRC_TABLE = build_crc_table();

    // one byte through the table-driven crc
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        return {crc[14:0], 1'b0} ^ CRC_TABLE[crc[15:8] ^ b];
    endfunction

endpackage

### rtl/core/idf_crc_cell.sv
module idf_crc_cell
    import idf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        shift_en,
    input  logic [15:0] crc_in,
    input  logic [7:0]  byte_in,
    output logic [15:0] crc_out
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    // crc over one more byte than the neighbor upstream
    assign crc_next = crc_step(crc_in, byte_in);
    assign crc_out  = crc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
        end else if (shift_en) begin
            crc_reg <= crc_next;
        end
    end

endmodule

### rtl/core/imu_frame_deframer_crc16_unit.sv
// result: a frame result is registered and shows in the cycle after its tail byte item is taken
// throughput: one byte item per cycle while s_ready is high; the crc cells update each byte
// one output register: the next item is taken in the cycle the result is taken
// reset: synchronous active-low aresetn clears window, crc cells, delay line,
// consume counter, frame counters and output valid
module imu_frame_deframer_crc16_unit
    import idf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_record_id,
    output logic [31:0] m_word_one,
    output logic [31:0] m_word_two,
    output logic [31:0] m_word_three,
    output logic [31:0] m_good_frames,
    output logic [31:0] m_crc_failures
);

    // byte window, entry 0 is the oldest byte
    logic [7:0]  win_reg  [FRAME_BYTES];
    logic [7:0]  win_next [FRAME_BYTES];

    // crc chain: cell j holds the crc over the last j+1 bytes
    logic [15:0] cell_crc [CRC_CELLS];
    logic [15:0] cell_in  [CRC_CELLS];

    // finished crcs, delayed so they line up with the frame start
    logic [15:0] full_d1_reg, full_d2_reg;
    logic [15:0] tail_d1_reg, tail_d2_reg;

    logic [4:0]  consume_reg, consume_next;
    logic [31:0] good_count_reg, good_count_next;
    logic [31:0] fail_count_reg, fail_count_next;
    logic        m_valid_reg;

    logic        take;
    logic        framed;
    logic        crc_ok;
    logic        frame_ok;
    logic        crc_bad;
    logic [15:0] wire_crc;

    // output register parts the channels, refilled as it drains
    assign s_ready = !m_valid_reg || m_ready;
    assign take    = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            win_next[i] = win_reg[i + 1];
        end
        win_next[FRAME_BYTES - 1] = s_rx_byte;
    end

    // cell 0 starts a fresh crc at every byte
    always_comb begin
        cell_in[0] = CRC_INIT;
        for (int j = 1; j < CRC_CELLS; j++) begin
            cell_in[j] = cell_crc[j - 1];
        end
    end

    genvar g;
    generate
        for (g = 0; g < CRC_CELLS; g++) begin : g_cell
            idf_crc_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (take),
                .crc_in   (cell_in[g]),
                .byte_in  (s_rx_byte),
                .crc_out  (cell_crc[g])
            );
        end
    endgenerate

    // when the tail arrives, the cells have just seen byte 17; two stages back
    // they had just seen byte 15, the last byte under the crc
    assign wire_crc = {win_next[17], win_next[16]};

    assign framed = (consume_reg == 5'd0)
                 && (win_next[0] == HDR_BYTE0)
                 && (win_next[1] == HDR_BYTE1)
                 && (win_next[FRAME_BYTES - 1] == TAIL_BYTE)
                 && (win_next[3] >= ID_MIN)
                 && (win_next[3] <= ID_MAX);

    assign crc_ok   = (full_d2_reg == wire_crc) || (tail_d2_reg == wire_crc);
    assign frame_ok = framed && crc_ok;
    assign crc_bad  = framed && !crc_ok;

    always_comb begin
        consume_next    = consume_reg;
        good_count_next = good_count_reg;
        fail_count_next = fail_count_reg;
        if (take) begin
            if (consume_reg != 5'd0) begin
                consume_next = consume_reg - 5'd1;
            end else if (frame_ok) begin
                // bytes of this frame never start another one
                consume_next    = 5'(FRAME_BYTES - 1);
                good_count_next = good_count_reg + 32'd1;
            end else if (crc_bad) begin
                fail_count_next = fail_count_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < FRAME_BYTES; i++) begin
                win_reg[i] <= 8'd0;
            end
            full_d1_reg    <= 16'd0;
            full_d2_reg    <= 16'd0;
            tail_d1_reg    <= 16'd0;
            tail_d2_reg    <= 16'd0;
            consume_reg    <= 5'd0;
            good_count_reg <= 32'd0;
            fail_count_reg <= 32'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (take) begin
                win_reg     <= win_next;
                full_d1_reg <= cell_crc[CRC_CELLS - 1];
                full_d2_reg <= full_d1_reg;
                tail_d1_reg <= cell_crc[CRC_CELLS - 3];
                tail_d2_reg <= tail_d1_reg;
            end
            consume_reg    <= consume_next;
            good_count_reg <= good_count_next;
            fail_count_reg <= fail_count_next;
            if (take && frame_ok) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded only with an accepted frame
    always_ff @(posedge aclk) begin
        if (take && frame_ok) begin
            m_record_id    <= win_next[3][1:0];
            m_word_one     <= {win_next[7],  win_next[6],  win_next[5],  win_next[4]};
            m_word_two     <= {win_next[11], win_next[10], win_next[9],  win_next[8]};
            m_word_three   <= {win_next[15], win_next[14], win_next[13], win_next[12]};
            m_good_frames  <= good_count_next;
            m_crc_failures <= fail_count_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_frame_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        take && frame_ok |=> m_valid)
        else $error("accepted frame produced no result");

    a_frame_consumes: assert property (@(posedge aclk) disable iff (!aresetn)
        take && frame_ok |=> consume_reg == 5'(FRAME_BYTES - 1))
        else $error("accepted frame did not start consumption");

    a_good_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        take && frame_ok |=> m_good_frames == $past(good_count_reg) + 32'd1)
        else $error("good frame count out of step");

    a_no_frame_while_consuming: assert property (@(posedge aclk) disable iff (!aresetn)
        consume_reg != 5'd0 |=> good_count_reg == $past(good_count_reg))
        else $error("frame accepted inside a consumed frame");
`endif

endmodule

### tb/sv/imu_frame_deframer_crc16_unit_tb.sv
`timescale 1ns / 1ps

module imu_frame_deframer_crc16_unit_tb
    import idf_pkg::*;
();

    localparam int CLK_HALF        = 2;
    localparam int RESET_CYCLES    = 12;
    localparam int RANDOM_ITEMS    = 1000;
    localparam int MIN_GOOD_FRAMES = 40;
    localparam int HOLD_CYCLES     = 300;   // one long sink hold-off, fills the output stage
    localparam int STALL_LIMIT     = 5000;  // cycles without any handshake before giving up
    localparam int DRAIN_CYCLES    = 20;    // result shows up in the cycle after the tail byte

    typedef logic [7:0] frame_t [FRAME_BYTES];

    // what kind of 19-byte sequence the generator lays down
    typedef enum int {
        FR_GOOD_FULL,   // crc over bytes 0-15
        FR_GOOD_SHORT,  // crc over bytes 2-15
        FR_BAD_CRC,
        FR_BAD_ID,
        FR_BAD_TAIL,
        FR_BAD_HDR
    } frame_kind_e;

    // handshake pressure, stepped through as the run progresses
    typedef enum int {
        PH_STEADY,
        PH_SENDER_GAPS,
        PH_SINK_STALLS,
        PH_BOTH_IDLE
    } traffic_phase_e;

    typedef struct {
        logic [1:0]  record_id;
        logic [31:0] word_one;
        logic [31:0] word_two;
        logic [31:0] word_three;
        logic [31:0] good_frames;
        logic [31:0] crc_failures;
    } frame_result_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte   = 8'h00;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [1:0]  m_record_id;
    logic [31:0] m_word_one;
    logic [31:0] m_word_two;
    logic [31:0] m_word_three;
    logic [31:0] m_good_frames;
    logic [31:0] m_crc_failures;

    imu_frame_deframer_crc16_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_record_id    (m_record_id),
        .m_word_one     (m_word_one),
        .m_word_two     (m_word_two),
        .m_word_three   (m_word_three),
        .m_good_frames  (m_good_frames),
        .m_crc_failures (m_crc_failures)
    );

    // byte stream still to be offered, and frame results still owed by the block
    logic [7:0]    rx_bytes_q[$];
    frame_result_t frame_results_q[$];

    int bytes_taken = 0;
    int total_bytes = 0;
    int errors      = 0;
    int idle_cycles = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    // deframer state as the predictor sees it, zeros after reset
    frame_t      window_bytes = '{default: 8'h00};
    logic [4:0]  skip_left    = '0;
    logic [31:0] good_total   = '0;
    logic [31:0] crc_fail_total = '0;

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // one table entry for polynomial 0x1021, shifted out msb first
    function automatic logic [15:0] poly_entry(input logic [7:0] idx);
        logic [15:0] v;
        logic        carry;
        v = {idx, 8'h00};
        for (int k = 0; k < 8; k++) begin
            carry = v[15];
            v = {v[14:0], 1'b0};
            if (carry) begin
                v = v ^ CRC_POLY;
            end
        end
        return v;
    endfunction

    // note the single-bit shift of the running value, not the usual byte shift
    function automatic logic [15:0] frame_crc(input frame_t f, input int first, input int count);
        logic [15:0] crc;
        crc = CRC_INIT;
        for (int i = 0; i < count; i++) begin
            crc = {crc[14:0], 1'b0} ^ poly_entry(crc[15:8] ^ f[first + i]);
        end
        return crc;
    endfunction

    // fill < 0 gives random content, id_sel < 0 a random legal id
    function automatic frame_t make_frame(input frame_kind_e kind, input int id_sel,
                                          input int fill);
        frame_t      f;
        logic [15:0] crc;
        int          at;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            f[i] = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
        end
        // a fake header inside the payload must not start a frame once consumed
        if (fill < 0 && $urandom_range(3) == 0) begin
            at = $urandom_range(4, 13);
            f[at]     = HDR_BYTE0;
            f[at + 1] = HDR_BYTE1;
        end
        f[0] = HDR_BYTE0;
        f[1] = HDR_BYTE1;
        f[3] = (id_sel >= 0) ? 8'(id_sel) : 8'($urandom_range(ID_MIN, ID_MAX));
        if (kind == FR_BAD_ID) begin
            f[3] = ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(4, 255));
        end
        if (kind == FR_GOOD_SHORT || (kind != FR_GOOD_FULL && $urandom_range(1) == 0)) begin
            crc = frame_crc(f, 2, 14);
        end else begin
            crc = frame_crc(f, 0, 16);
        end
        if (kind == FR_BAD_CRC) begin
            crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        end
        f[16] = crc[7:0];
        f[17] = crc[15:8];
        f[18] = TAIL_BYTE;
        if (kind == FR_BAD_TAIL) begin
            f[18] = TAIL_BYTE ^ 8'($urandom_range(1, 255));
        end
        if (kind == FR_BAD_HDR) begin
            at = $urandom_range(1);
            f[at] = f[at] ^ 8'($urandom_range(1, 255));
        end
        return f;
    endfunction

    // queue the first len bytes of a frame, a short len leaves a broken frame
    task automatic push_bytes(input frame_t f, input int len);
        for (int i = 0; i < len; i++) begin
            rx_bytes_q = {rx_bytes_q, f[i]};
        end
    endtask

    // slide the window by one byte and test the frame at its oldest byte
    function automatic void track_byte(input logic [7:0] b);
        logic [15:0]   rx_crc;
        frame_result_t res;
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            window_bytes[i] = window_bytes[i + 1];
        end
        window_bytes[FRAME_BYTES - 1] = b;
        // bytes of an accepted frame only shift through
        if (skip_left != 0) begin
            skip_left = skip_left - 1'b1;
            return;
        end
        if (window_bytes[0] != HDR_BYTE0 || window_bytes[1] != HDR_BYTE1 ||
            window_bytes[FRAME_BYTES - 1] != TAIL_BYTE) begin
            return;
        end
        if (window_bytes[3] < ID_MIN || window_bytes[3] > ID_MAX) begin
            return;
        end
        rx_crc = {window_bytes[17], window_bytes[16]};
        // either crc span is good enough, only a double miss is counted
        if (frame_crc(window_bytes, 0, 16) != rx_crc &&
            frame_crc(window_bytes, 2, 14) != rx_crc) begin
            crc_fail_total = crc_fail_total + 1;
            return;
        end
        good_total   = good_total + 1;
        skip_left    = 5'(FRAME_BYTES - 1);
        res.record_id    = window_bytes[3][1:0];
        res.word_one     = {window_bytes[7], window_bytes[6], window_bytes[5], window_bytes[4]};
        res.word_two     = {window_bytes[11], window_bytes[10], window_bytes[9], window_bytes[8]};
        res.word_three   = {window_bytes[15], window_bytes[14], window_bytes[13], window_bytes[12]};
        res.good_frames  = good_total;
        res.crc_failures = crc_fail_total;
        frame_results_q = {frame_results_q, res};
    endfunction

    function automatic traffic_phase_e traffic_phase();
        if (total_bytes == 0) begin
            return PH_STEADY;
        end
        unique case (bytes_taken * 4 / total_bytes)
            1: return PH_SENDER_GAPS;
            2: return PH_SINK_STALLS;
            3: return PH_BOTH_IDLE;
            default: return PH_STEADY;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // byte driver: offer the queue front, pop it and predict once taken
    always @(posedge aclk) begin : drive_bytes
        int gap_pct;
        traffic_phase_e ph;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                track_byte(s_rx_byte);
                rx_bytes_q.delete(0);
                bytes_taken <= bytes_taken + 1;
            end
            ph = traffic_phase();
            gap_pct = (ph == PH_SENDER_GAPS) ? 50 : (ph == PH_BOTH_IDLE) ? 29 : 0;
            // only move on once the offered byte is gone
            if (!s_valid || s_ready) begin
                if (rx_bytes_q.size() > 0 && $urandom_range(99) >= gap_pct) begin
                    s_valid   <= 1'b1;
                    s_rx_byte <= rx_bytes_q[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and sink-side backpressure
    always @(posedge aclk) begin : watch_results
        frame_result_t want;
        int stall_pct;
        traffic_phase_e ph;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (frame_results_q.size() == 0) begin
                    $error("frame result with none pending, record_id %0d good_frames %0d",
                           m_record_id, m_good_frames);
                    errors++;
                end else begin
                    want = frame_results_q.pop_front();
                    check_field("record_id", 32'(want.record_id), 32'(m_record_id));
                    check_field("word_one", want.word_one, m_word_one);
                    check_field("word_two", want.word_two, m_word_two);
                    check_field("word_three", want.word_three, m_word_three);
                    check_field("good_frames", want.good_frames, m_good_frames);
                    check_field("crc_failures", want.crc_failures, m_crc_failures);
                end
            end
            ph = traffic_phase();
            stall_pct = (ph == PH_SINK_STALLS) ? 50 : (ph == PH_BOTH_IDLE) ? 29 : 0;
            // long hold-off early on while bytes keep streaming in
            if (hold_left > 0) begin
                m_ready   <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!hold_done && bytes_taken >= total_bytes / 8 && total_bytes > 0) begin
                m_ready   <= 1'b0;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge aclk) begin : progress_watch
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int directed_bytes;
        int good_made;
        int pick;
        int noise_len;
        frame_t f;

        // directed: a frame right after reset while the window still holds zeros,
        // extreme payloads and ids, both crc spans, and a crc reject
        push_bytes(make_frame(FR_GOOD_SHORT, ID_MAX, 8'hFF), FRAME_BYTES);
        push_bytes(make_frame(FR_BAD_CRC, ID_MIN, 8'h00), FRAME_BYTES);
        push_bytes(make_frame(FR_GOOD_FULL, ID_MIN, 8'h00), FRAME_BYTES);
        directed_bytes = rx_bytes_q.size();

        // random: mostly well-formed frames, some broken ones and line noise
        good_made = 2;
        while (rx_bytes_q.size() < directed_bytes + RANDOM_ITEMS ||
               good_made < MIN_GOOD_FRAMES) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                push_bytes(make_frame(FR_GOOD_FULL, -1, -1), FRAME_BYTES);
                good_made++;
            end else if (pick < 65) begin
                push_bytes(make_frame(FR_GOOD_SHORT, -1, -1), FRAME_BYTES);
                good_made++;
            end else if (pick < 72) begin
                push_bytes(make_frame(FR_BAD_CRC, -1, -1), FRAME_BYTES);
            end else if (pick < 77) begin
                push_bytes(make_frame(FR_BAD_ID, -1, -1), FRAME_BYTES);
            end else if (pick < 81) begin
                push_bytes(make_frame(FR_BAD_TAIL, -1, -1), FRAME_BYTES);
            end else if (pick < 85) begin
                push_bytes(make_frame(FR_BAD_HDR, -1, -1), FRAME_BYTES);
            end else if (pick < 92) begin
                // frame cut short, the next one has to be found inside the window
                push_bytes(make_frame(FR_GOOD_FULL, -1, -1), $urandom_range(2, FRAME_BYTES - 1));
            end else begin
                noise_len = $urandom_range(1, 8);
                for (int i = 0; i < noise_len; i++) begin
                    f[i] = ($urandom_range(3) == 0) ? HDR_BYTE0 : 8'($urandom_range(255));
                end
                push_bytes(f, noise_len);
            end
        end
        total_bytes = rx_bytes_q.size();

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // all bytes taken and every predicted frame seen
        while (rx_bytes_q.size() != 0 || frame_results_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/idf_pkg.sv
rtl/core/idf_crc_cell.sv
rtl/core/imu_frame_deframer_crc16_unit.sv
tb/sv/imu_frame_deframer_crc16_unit_tb.sv
